/* rtl/core/script_lexer_tokenizer_unit_assert.svh */
// Assertion macros for the script lexer tokenizer.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SCRIPT_LEXER_TOKENIZER_UNIT_ASSERT_SVH
`define SCRIPT_LEXER_TOKENIZER_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SLT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SLT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/slt_pkg.sv */
// Shared types, constants and lexer step functions for the script lexer tokenizer.
// No dependencies; used by slt_if.sv and script_lexer_tokenizer_unit.sv.
`default_nettype none

package slt_pkg;

  localparam int POS_BITS  = 32;
  localparam int LEN_BITS  = 16;
  localparam int LINE_BITS = 24;
  localparam int CH_BITS   = 8;

  // Result buffering
  localparam int MAX_RES   = 3;
  localparam int NUM_CAND  = 4;
  localparam int RES_DEPTH = 4;
  localparam int PTR_W     = $clog2(RES_DEPTH);
  localparam int CNT_W     = $clog2(RES_DEPTH + 1);
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int ROOM_MAX  = RES_DEPTH - MAX_RES;

  localparam logic [POS_BITS-1:0]  POS_MAX  = '1;
  localparam logic [LEN_BITS-1:0]  LEN_MAX  = '1;
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  // Character codes
  localparam logic [CH_BITS-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_BITS-1:0] CH_NL     = 8'h0A;
  localparam logic [CH_BITS-1:0] CH_SP     = 8'h20;
  localparam logic [CH_BITS-1:0] CH_BANG   = 8'h21;
  localparam logic [CH_BITS-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CH_BITS-1:0] CH_HASH   = 8'h23;
  localparam logic [CH_BITS-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CH_BITS-1:0] CH_LT     = 8'h3C;
  localparam logic [CH_BITS-1:0] CH_EQ     = 8'h3D;
  localparam logic [CH_BITS-1:0] CH_GT     = 8'h3E;
  localparam logic [CH_BITS-1:0] CH_QUEST  = 8'h3F;
  localparam logic [CH_BITS-1:0] CH_UNDER  = 8'h5F;
  localparam logic [CH_BITS-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CH_BITS-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CH_BITS-1:0] CH_E      = 8'h65;
  localparam logic [CH_BITS-1:0] CH_F      = 8'h66;
  localparam logic [CH_BITS-1:0] CH_H      = 8'h68;
  localparam logic [CH_BITS-1:0] CH_I      = 8'h69;
  localparam logic [CH_BITS-1:0] CH_L      = 8'h6C;
  localparam logic [CH_BITS-1:0] CH_W      = 8'h77;

  typedef enum logic [2:0] {
    KIND_IDENT   = 3'd0,
    KIND_KEYWORD = 3'd1,
    KIND_CONST   = 3'd2,
    KIND_STRING  = 3'd3,
    KIND_OP      = 3'd4,
    KIND_PUNCT   = 3'd5,
    KIND_DEFECT  = 3'd6
  } kind_t;

  typedef enum logic [6:0] {
    MODE_HOME    = 7'b0000001,
    MODE_IDENT   = 7'b0000010,
    MODE_WORD    = 7'b0000100,
    MODE_NUM     = 7'b0001000,
    MODE_STR     = 7'b0010000,
    MODE_EQ      = 7'b0100000,
    MODE_COMMENT = 7'b1000000
  } mode_t;

  typedef enum logic [7:0] {
    KW_NONE  = 8'b00000001,
    KW_I     = 8'b00000010,
    KW_IF    = 8'b00000100,
    KW_W     = 8'b00001000,
    KW_WH    = 8'b00010000,
    KW_WHI   = 8'b00100000,
    KW_WHIL  = 8'b01000000,
    KW_WHILE = 8'b10000000
  } kw_t;

  typedef struct packed {
    mode_t                 mode;
    logic                  need_sep;
    logic [LINE_BITS-1:0]  line;
    logic [POS_BITS-1:0]   pos;
    logic [POS_BITS-1:0]   start;
    logic [LEN_BITS-1:0]   len;
    kw_t                   kw;
  } lex_st_t;

  // One pass: state after it, reprocess flag, separator defect and token
  typedef struct packed {
    lex_st_t               st;
    logic                  again;
    logic                  d_vld;
    logic [POS_BITS-1:0]   d_start;
    logic [LEN_BITS-1:0]   d_len;
    logic                  t_vld;
    kind_t                 t_kind;
    logic [POS_BITS-1:0]   t_start;
    logic [LEN_BITS-1:0]   t_len;
  } pass_t;

  typedef struct packed {
    kind_t                 kind;
    logic [LINE_BITS-1:0]  line_no;
    logic [POS_BITS-1:0]   start_pos;
    logic [LEN_BITS-1:0]   tok_len;
    logic                  last;
  } res_t;

  function automatic logic is_ws(logic [CH_BITS-1:0] c);
    return c inside {CH_SP, CH_TAB, CH_NL};
  endfunction

  function automatic logic is_op(logic [CH_BITS-1:0] c);
    return c inside {"+", "-", "*", "/", "&", "|", "!", "<", ">",
                     "(", ")", "[", "]", ";", ","};
  endfunction

  function automatic logic is_lower(logic [CH_BITS-1:0] c);
    return c inside {["a":"z"]};
  endfunction

  function automatic logic is_upper(logic [CH_BITS-1:0] c);
    return c inside {["A":"Z"]};
  endfunction

  function automatic logic is_digit(logic [CH_BITS-1:0] c);
    return c inside {["0":"9"]};
  endfunction

  // Bytes allowed right after a token that needs a separator
  function automatic logic is_sep(logic [CH_BITS-1:0] c);
    return is_ws(c) || is_op(c) || (c inside {CH_LBRACE, CH_RBRACE, CH_EQ});
  endfunction

  function automatic kw_t kw_advance(kw_t km, logic [CH_BITS-1:0] c);
    kw_t k;
    k = KW_NONE;
    case (km)
      KW_I:    if (c == CH_F) k = KW_IF;
      KW_W:    if (c == CH_H) k = KW_WH;
      KW_WH:   if (c == CH_I) k = KW_WHI;
      KW_WHI:  if (c == CH_L) k = KW_WHIL;
      KW_WHIL: if (c == CH_E) k = KW_WHILE;
      default: k = KW_NONE;
    endcase
    return k;
  endfunction

  // Add the current byte to the token, saturating the length
  function automatic lex_st_t append(lex_st_t s);
    lex_st_t r;
    r = s;
    if (r.len == '0) r.start = r.pos;
    if (r.len != LEN_MAX) r.len = r.len + 1'b1;
    return r;
  endfunction

  // Close the token in progress; an empty token gives nothing
  function automatic pass_t emit_tok(pass_t p, kind_t k);
    pass_t r;
    r = p;
    r.t_vld   = (r.st.len != '0);
    r.t_kind  = k;
    r.t_start = r.st.start;
    r.t_len   = r.st.len;
    r.st.len  = '0;
    return r;
  endfunction

  // One lexer pass over byte c
  function automatic pass_t lex_pass(lex_st_t s, logic [CH_BITS-1:0] c);
    pass_t p;
    p = '0;
    p.st = s;
    // Flag a missing separator as a one-byte defect
    if (p.st.need_sep) begin
      p.st.need_sep = 1'b0;
      if (!is_sep(c)) begin
        p.st = append(p.st);
        p.d_vld   = 1'b1;
        p.d_start = p.st.start;
        p.d_len   = p.st.len;
        p.st.len  = '0;
      end
    end
    case (p.st.mode)
      MODE_IDENT: begin
        if (is_lower(c) || is_upper(c) || is_digit(c) || c == CH_UNDER) begin
          p.st = append(p.st);
        end else begin
          p = emit_tok(p, KIND_IDENT);
          p.again       = 1'b1;
          p.st.need_sep = 1'b1;
          p.st.mode     = MODE_HOME;
        end
      end
      MODE_WORD: begin
        if (is_lower(c)) begin
          p.st    = append(p.st);
          p.st.kw = kw_advance(p.st.kw, c);
        end else begin
          if (p.st.kw == KW_IF || p.st.kw == KW_WHILE) begin
            p = emit_tok(p, KIND_KEYWORD);
            p.st.need_sep = 1'b1;
          end else begin
            p = emit_tok(p, KIND_DEFECT);
          end
          p.again   = 1'b1;
          p.st.mode = MODE_HOME;
        end
      end
      MODE_NUM: begin
        if (is_digit(c)) begin
          p.st = append(p.st);
        end else begin
          p = emit_tok(p, KIND_CONST);
          p.again       = 1'b1;
          p.st.need_sep = 1'b1;
          p.st.mode     = MODE_HOME;
        end
      end
      MODE_STR: begin
        if (c != CH_QUOTE) begin
          p.st = append(p.st);
        end else begin
          p = emit_tok(p, KIND_STRING);
          p.st.need_sep = 1'b1;
          p.st.mode     = MODE_HOME;
        end
      end
      MODE_EQ: begin
        if (c inside {CH_EQ, CH_BANG, CH_LT, CH_GT}) begin
          p.st = append(p.st);
          p = emit_tok(p, KIND_OP);
        end else begin
          p = emit_tok(p, KIND_OP);
          p.again = 1'b1;
        end
        p.st.mode = MODE_HOME;
      end
      MODE_COMMENT: begin
        if (c == CH_NL) p.st.mode = MODE_HOME;
      end
      // Home mode; any unused code behaves the same way
      default: begin
        p.st.mode = MODE_HOME;
        if (c == CH_HASH) begin
          p.st.mode = MODE_COMMENT;
        end else if (c == CH_QUOTE) begin
          p.st.mode = MODE_STR;
        end else if (!is_ws(c)) begin
          p.st = append(p.st);
          if (is_op(c)) begin
            p = emit_tok(p, KIND_OP);
          end else if (c == CH_LBRACE || c == CH_RBRACE) begin
            p = emit_tok(p, KIND_PUNCT);
          end else if (c == CH_DOLLAR || c == CH_QUEST) begin
            p.st.mode = MODE_IDENT;
          end else if (is_lower(c)) begin
            p.st.mode = MODE_WORD;
            p.st.kw   = (c == CH_I) ? KW_I : ((c == CH_W) ? KW_W : KW_NONE);
          end else if (is_digit(c)) begin
            p.st.mode = MODE_NUM;
          end else if (c == CH_EQ) begin
            p.st.mode = MODE_EQ;
          end else begin
            p = emit_tok(p, KIND_DEFECT);
          end
        end
      end
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/slt_if.sv */
// Handshake interfaces for the script lexer tokenizer: byte input and token output.
// Depends on slt_pkg for payload widths and the token kind type.
`default_nettype none

interface slt_in_if;
  logic                          valid;
  logic                          ready;
  logic [slt_pkg::CH_BITS-1:0]   ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface slt_out_if;
  logic                          valid;
  logic                          ready;
  slt_pkg::kind_t                kind;
  logic [slt_pkg::LINE_BITS-1:0] line_no;
  logic [slt_pkg::POS_BITS-1:0]  start_pos;
  logic [slt_pkg::LEN_BITS-1:0]  tok_len;
  logic                          last;

  modport source (output valid, output kind, output line_no, output start_pos,
                  output tok_len, output last, input ready);
  modport sink   (input valid, input kind, input line_no, input start_pos,
                  input tok_len, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/script_lexer_tokenizer_unit.sv */
// Script lexer tokenizer: one source byte per beat in, one token per beat out.
// Depends on slt_pkg, slt_if.sv and script_lexer_tokenizer_unit_assert.svh.
//
// Usage:
//   in_bus carries one source byte per beat (valid/ready). out_bus carries one
//   token per beat: kind, line number, start offset, length and a last flag
//   that marks the final token caused by one input byte.
//   A byte is captured in an input register; when the queue has room the lexer
//   state update (including the reprocess pass in home mode) runs in one
//   combinational step and writes 0 to 3 tokens into a 4-entry result queue.
//   A token is offered on out_bus from the queue head, after its byte has
//   passed through the input register and the result queue.
//   Throughput: one byte per cycle while the queue holds at most one token,
//   so one token per byte streams at full rate; bytes producing 2 or 3 tokens
//   are limited by the single output beat per cycle.
//   A stall on out_bus fills the queue; the input register then holds its
//   byte and in_bus.ready drops until room for three tokens is free.
//   Reset (rst_n low, synchronous) empties the queue and input register and
//   returns the lexer to home mode, line 1, offset 0.
`default_nettype none
`include "script_lexer_tokenizer_unit_assert.svh"

module script_lexer_tokenizer_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  slt_in_if.sink     in_bus,
  slt_out_if.source  out_bus
);

  // Input register
  logic                          s1_vld_r;
  logic [slt_pkg::CH_BITS-1:0]   s1_ch_r;
  logic                          s1_go;
  logic                          room;

  // Lexer state and step
  slt_pkg::lex_st_t              st_r;
  slt_pkg::lex_st_t              st_nxt;
  slt_pkg::lex_st_t              st_after;
  slt_pkg::pass_t                p1;
  slt_pkg::pass_t                p2;

  // Token candidates and packed slots
  slt_pkg::res_t                 cand [slt_pkg::NUM_CAND];
  logic [slt_pkg::NUM_CAND-1:0]  cand_vld;
  slt_pkg::res_t                 slot [slt_pkg::MAX_RES];
  logic [slt_pkg::RES_CNT_W-1:0] n_res;
  logic [slt_pkg::RES_CNT_W-1:0] push_n;

  // Result queue
  slt_pkg::res_t                 res_mem_r [slt_pkg::RES_DEPTH];
  logic [slt_pkg::PTR_W-1:0]     wr_ptr_r;
  logic [slt_pkg::PTR_W-1:0]     rd_ptr_r;
  logic [slt_pkg::CNT_W-1:0]     cnt_r;
  logic [slt_pkg::CNT_W-1:0]     cnt_nxt;
  logic                          pop;
  slt_pkg::res_t                 head;

  // Accept a byte when the input register is empty or moves on this cycle
  assign room          = (cnt_r <= slt_pkg::CNT_W'(slt_pkg::ROOM_MAX));
  assign s1_go         = s1_vld_r && room;
  assign in_bus.ready  = !s1_vld_r || room;

  // Run the lexer pass, then the reprocess pass if the byte ended a token
  always_comb begin
    p1 = slt_pkg::lex_pass(st_r, s1_ch_r);
    p2 = slt_pkg::lex_pass(p1.st, s1_ch_r);
    st_after = p1.again ? p2.st : p1.st;
    st_nxt = st_after;
    if (s1_ch_r == slt_pkg::CH_NL && st_after.line != slt_pkg::LINE_MAX) begin
      st_nxt.line = st_after.line + 1'b1;
    end
    if (st_after.pos != slt_pkg::POS_MAX) begin
      st_nxt.pos = st_after.pos + 1'b1;
    end
  end

  // Gather candidates in stream order
  always_comb begin
    cand_vld = {p1.again & p2.t_vld, p1.again & p2.d_vld, p1.t_vld, p1.d_vld};
    cand[0] = '{kind: slt_pkg::KIND_DEFECT, line_no: st_r.line,
                start_pos: p1.d_start, tok_len: p1.d_len, last: 1'b0};
    cand[1] = '{kind: p1.t_kind, line_no: st_r.line,
                start_pos: p1.t_start, tok_len: p1.t_len, last: 1'b0};
    cand[2] = '{kind: slt_pkg::KIND_DEFECT, line_no: st_r.line,
                start_pos: p2.d_start, tok_len: p2.d_len, last: 1'b0};
    cand[3] = '{kind: p2.t_kind, line_no: st_r.line,
                start_pos: p2.t_start, tok_len: p2.t_len, last: 1'b0};
  end

  // Pack valid candidates into consecutive slots and mark the final one
  always_comb begin
    n_res = '0;
    for (int k = 0; k < slt_pkg::MAX_RES; k++) begin
      slot[k] = '0;
    end
    for (int i = 0; i < slt_pkg::NUM_CAND; i++) begin
      if (cand_vld[i] && n_res < slt_pkg::RES_CNT_W'(slt_pkg::MAX_RES)) begin
        slot[n_res] = cand[i];
        n_res = n_res + 1'b1;
      end
    end
    if (n_res != '0) begin
      slot[n_res - 1'b1].last = 1'b1;
    end
  end

  assign push_n  = s1_go ? n_res : '0;
  assign pop     = out_bus.valid && out_bus.ready;
  assign cnt_nxt = cnt_r + slt_pkg::CNT_W'(push_n) - slt_pkg::CNT_W'(pop);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r      <= 1'b0;
      st_r.mode     <= slt_pkg::MODE_HOME;
      st_r.need_sep <= 1'b0;
      st_r.line     <= slt_pkg::LINE_BITS'(1);
      st_r.pos      <= '0;
      st_r.start    <= '0;
      st_r.len      <= '0;
      st_r.kw       <= slt_pkg::KW_NONE;
      wr_ptr_r      <= '0;
      rd_ptr_r      <= '0;
      cnt_r         <= '0;
    end else begin
      if (in_bus.ready) begin
        s1_vld_r <= in_bus.valid;
      end
      if (s1_go) begin
        st_r <= st_nxt;
      end
      wr_ptr_r <= wr_ptr_r + slt_pkg::PTR_W'(push_n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Capture the input byte
  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      s1_ch_r <= in_bus.ch;
    end
  end

  // Write packed tokens into the queue
  always_ff @(posedge clk) begin
    for (int k = 0; k < slt_pkg::MAX_RES; k++) begin
      if (slt_pkg::RES_CNT_W'(k) < push_n) begin
        res_mem_r[wr_ptr_r + slt_pkg::PTR_W'(k)] <= slot[k];
      end
    end
  end

  // Drive the output beat from the queue head
  assign head              = res_mem_r[rd_ptr_r];
  assign out_bus.valid     = (cnt_r != '0);
  assign out_bus.kind      = head.kind;
  assign out_bus.line_no   = head.line_no;
  assign out_bus.start_pos = head.start_pos;
  assign out_bus.tok_len   = head.tok_len;
  assign out_bus.last      = head.last;

  // Checks
  `SLT_HOLDS(a_queue_count, 1'b1,
    (cnt_r <= slt_pkg::RES_DEPTH) &&
    (slt_pkg::PTR_W'(cnt_r) == slt_pkg::PTR_W'(wr_ptr_r - rd_ptr_r)),
    "queue count out of step with pointers")
  `SLT_HOLDS(a_sep_home, st_r.need_sep,
    st_r.mode == slt_pkg::MODE_HOME, "separator check armed outside home mode")
  `SLT_HOLDS(a_home_empty, st_r.mode == slt_pkg::MODE_HOME,
    st_r.len == '0, "token in progress while in home mode")
  `SLT_NEXT(a_push_shows, s1_go && (n_res != '0),
    out_bus.valid, "pushed token not offered")

endmodule

`default_nettype wire

/* sim/script_lexer_token_check.sv */
// Token checker for the script lexer: watches both channels, predicts tokens, compares.
// Depends on slt_pkg (token kind, result struct, widths, byte codes) and slt_if.sv.
module script_lexer_token_check (
  input  logic        clk,
  input  logic        rst_n,
  slt_in_if           byte_mon,
  slt_out_if          token_mon,
  output int unsigned tokens_outstanding,
  output int unsigned mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [6:0] {
    LX_HOME    = 7'b0000001,
    LX_IDENT   = 7'b0000010,
    LX_WORD    = 7'b0000100,
    LX_NUM     = 7'b0001000,
    LX_STR     = 7'b0010000,
    LX_EQ      = 7'b0100000,
    LX_COMMENT = 7'b1000000
  } lex_mode_t;

  // Progress through the two keywords, one letter at a time
  typedef enum logic [7:0] {
    WM_NONE  = 8'b00000001,
    WM_I     = 8'b00000010,
    WM_IF    = 8'b00000100,
    WM_W     = 8'b00001000,
    WM_WH    = 8'b00010000,
    WM_WHI   = 8'b00100000,
    WM_WHIL  = 8'b01000000,
    WM_WHILE = 8'b10000000
  } word_match_t;

  lex_mode_t                      mode_q;
  logic                           sep_due;
  logic [slt_pkg::LINE_BITS-1:0]  line_cnt;
  logic [slt_pkg::POS_BITS-1:0]   byte_ofs;
  logic [slt_pkg::POS_BITS-1:0]   tok_start;
  logic [slt_pkg::LEN_BITS-1:0]   tok_chars;
  word_match_t                    word_state;

  slt_pkg::res_t                  step_tokens[$];
  slt_pkg::res_t                  expected_tokens[$];
  int unsigned                    errors = 0;

  assign mismatch_count = errors;

  function automatic bit op_byte(logic [7:0] c);
    case (c)
      "+", "-", "*", "/", "&", "|", "!", "<", ">",
      "(", ")", "[", "]", ";", ",": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit space_byte(logic [7:0] c);
    return c == slt_pkg::CH_SP || c == slt_pkg::CH_TAB || c == slt_pkg::CH_NL;
  endfunction

  function automatic bit lower_byte(logic [7:0] c);
    return c >= "a" && c <= "z";
  endfunction

  function automatic bit digit_byte(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Add the current byte to the token in progress; length saturates
  task automatic take_char();
    if (tok_chars == '0) tok_start = byte_ofs;
    if (tok_chars != '1) tok_chars = tok_chars + 1'b1;
  endtask

  // Finish the token in progress; an empty one yields nothing
  task automatic close_token(slt_pkg::kind_t k);
    slt_pkg::res_t t;
    if (tok_chars != '0) begin
      t.kind      = k;
      t.line_no   = line_cnt;
      t.start_pos = tok_start;
      t.tok_len   = tok_chars;
      t.last      = 1'b0;
      step_tokens.push_back(t);
    end
    tok_chars = '0;
  endtask

  task automatic lex_one_pass(input logic [7:0] c, output bit again);
    again = 1'b0;
    // A token that wants a separator turns any other byte into a defect
    if (sep_due) begin
      sep_due = 1'b0;
      if (!(space_byte(c) || op_byte(c) || c == slt_pkg::CH_LBRACE ||
            c == slt_pkg::CH_RBRACE || c == slt_pkg::CH_EQ)) begin
        take_char();
        close_token(slt_pkg::KIND_DEFECT);
      end
    end
    case (mode_q)
      LX_IDENT: begin
        if (lower_byte(c) || (c >= "A" && c <= "Z") || digit_byte(c) ||
            c == slt_pkg::CH_UNDER) begin
          take_char();
        end else begin
          close_token(slt_pkg::KIND_IDENT);
          again   = 1'b1;
          sep_due = 1'b1;
          mode_q  = LX_HOME;
        end
      end
      LX_WORD: begin
        if (lower_byte(c)) begin
          take_char();
          case (word_state)
            WM_I:    word_state = (c == slt_pkg::CH_F) ? WM_IF : WM_NONE;
            WM_W:    word_state = (c == slt_pkg::CH_H) ? WM_WH : WM_NONE;
            WM_WH:   word_state = (c == slt_pkg::CH_I) ? WM_WHI : WM_NONE;
            WM_WHI:  word_state = (c == slt_pkg::CH_L) ? WM_WHIL : WM_NONE;
            WM_WHIL: word_state = (c == slt_pkg::CH_E) ? WM_WHILE : WM_NONE;
            default: word_state = WM_NONE;
          endcase
        end else begin
          // Plain words end as defects and skip the separator check
          if (word_state == WM_IF || word_state == WM_WHILE) begin
            close_token(slt_pkg::KIND_KEYWORD);
            sep_due = 1'b1;
          end else begin
            close_token(slt_pkg::KIND_DEFECT);
          end
          again  = 1'b1;
          mode_q = LX_HOME;
        end
      end
      LX_NUM: begin
        if (digit_byte(c)) begin
          take_char();
        end else begin
          close_token(slt_pkg::KIND_CONST);
          again   = 1'b1;
          sep_due = 1'b1;
          mode_q  = LX_HOME;
        end
      end
      LX_STR: begin
        if (c != slt_pkg::CH_QUOTE) begin
          take_char();
        end else begin
          close_token(slt_pkg::KIND_STRING);
          sep_due = 1'b1;
          mode_q  = LX_HOME;
        end
      end
      LX_EQ: begin
        if (c == slt_pkg::CH_EQ || c == slt_pkg::CH_BANG || c == slt_pkg::CH_LT ||
            c == slt_pkg::CH_GT) begin
          take_char();
          close_token(slt_pkg::KIND_OP);
        end else begin
          close_token(slt_pkg::KIND_OP);
          again = 1'b1;
        end
        mode_q = LX_HOME;
      end
      LX_COMMENT: begin
        if (c == slt_pkg::CH_NL) mode_q = LX_HOME;
      end
      default: begin
        mode_q = LX_HOME;
        if (c == slt_pkg::CH_HASH) begin
          mode_q = LX_COMMENT;
        end else if (c == slt_pkg::CH_QUOTE) begin
          mode_q = LX_STR;
        end else if (!space_byte(c)) begin
          take_char();
          if (op_byte(c)) begin
            close_token(slt_pkg::KIND_OP);
          end else if (c == slt_pkg::CH_LBRACE || c == slt_pkg::CH_RBRACE) begin
            close_token(slt_pkg::KIND_PUNCT);
          end else if (c == slt_pkg::CH_DOLLAR || c == slt_pkg::CH_QUEST) begin
            mode_q = LX_IDENT;
          end else if (lower_byte(c)) begin
            mode_q     = LX_WORD;
            word_state = (c == slt_pkg::CH_I) ? WM_I :
                         ((c == slt_pkg::CH_W) ? WM_W : WM_NONE);
          end else if (digit_byte(c)) begin
            mode_q = LX_NUM;
          end else if (c == slt_pkg::CH_EQ) begin
            mode_q = LX_EQ;
          end else begin
            close_token(slt_pkg::KIND_DEFECT);
          end
        end
      end
    endcase
  endtask

  // Run one source byte, second pass included, and queue its tokens
  task automatic lex_byte(input logic [7:0] c);
    bit again;
    bit again2;
    step_tokens.delete();
    lex_one_pass(c, again);
    if (again) lex_one_pass(c, again2);
    if (c == slt_pkg::CH_NL && line_cnt != '1) line_cnt = line_cnt + 1'b1;
    if (byte_ofs != '1) byte_ofs = byte_ofs + 1'b1;
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endtask

  always @(posedge clk) begin : watch_beats
    slt_pkg::res_t got;
    slt_pkg::res_t want;
    if (!rst_n) begin
      mode_q     = LX_HOME;
      sep_due    = 1'b0;
      line_cnt   = slt_pkg::LINE_BITS'(1);
      byte_ofs   = '0;
      tok_start  = '0;
      tok_chars  = '0;
      word_state = WM_NONE;
      expected_tokens.delete();
    end else begin
      // Predict on each byte beat
      if (byte_mon.valid && byte_mon.ready) lex_byte(byte_mon.ch);
      // Compare each token beat with the oldest prediction
      if (token_mon.valid && token_mon.ready) begin
        got.kind      = token_mon.kind;
        got.line_no   = token_mon.line_no;
        got.start_pos = token_mon.start_pos;
        got.tok_len   = token_mon.tok_len;
        got.last      = token_mon.last;
        if (expected_tokens.size() == 0) begin
          errors++;
          $display("%0t: token beat with none expected", $time);
          $display("%0t:   actual kind %0d line %0d start %0d len %0d last %0d",
                   $time, got.kind, got.line_no, got.start_pos, got.tok_len, got.last);
        end else begin
          want = expected_tokens.pop_front();
          if (got.kind !== want.kind || got.line_no !== want.line_no ||
              got.start_pos !== want.start_pos || got.tok_len !== want.tok_len ||
              got.last !== want.last) begin
            errors++;
            $display("%0t: token mismatch: expected kind %0d line %0d start %0d len %0d last %0d",
                     $time, want.kind, want.line_no, want.start_pos, want.tok_len,
                     want.last);
            $display("%0t:   actual kind %0d line %0d start %0d len %0d last %0d",
                     $time, got.kind, got.line_no, got.start_pos, got.tok_len, got.last);
          end
        end
      end
    end
    tokens_outstanding <= expected_tokens.size();
  end

endmodule

/* sim/tb_script_lexer_tokenizer_unit.sv */
// Testbench top for script_lexer_tokenizer_unit: clock, reset, byte stimulus and verdict.
// Depends on slt_pkg, slt_if.sv, the RTL and script_lexer_token_check.sv.
module tb_script_lexer_tokenizer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SOURCE_BYTES  = 210;
  localparam int HOLD_AFTER    = 120;
  localparam int HOLD_CYCLES   = 120;
  localparam int SETTLE_CYCLES = 32;

  logic        clk;
  logic        rst_n;
  int unsigned tokens_outstanding;
  int unsigned mismatch_count;
  int unsigned bytes_accepted;
  int unsigned idle_cycles;
  logic [7:0]  source_text[$];

  slt_in_if  in_bus();
  slt_out_if out_bus();

  script_lexer_tokenizer_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  script_lexer_token_check token_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .byte_mon           (in_bus),
    .token_mon          (out_bus),
    .tokens_outstanding (tokens_outstanding),
    .mismatch_count     (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count byte beats and end the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles    <= 0;
      bytes_accepted <= 0;
    end else begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (in_bus.valid && in_bus.ready) bytes_accepted <= bytes_accepted + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("** script_lexer_tokenizer_unit: FAILED **");
        $finish;
      end
    end
  end

  // Token sink: ready patterns that change at random phase lengths, plus one long hold
  initial begin
    int unsigned phase_left;
    int unsigned style;
    bit          held;
    out_bus.ready <= 1'b0;
    phase_left = 0;
    style      = 0;
    held       = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!held && bytes_accepted >= HOLD_AFTER) begin
        // Hold off long enough to fill the result queue and stall the input
        held = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(8, 64);
          style      = $urandom_range(0, 2);
        end
        phase_left--;
        case (style)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= ($urandom_range(0, 1) == 1);
          default: out_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Build the source text, stream it in bursts, then drain and judge
  initial begin
    string       directed;
    string       op_set;
    int unsigned n;
    int unsigned burst_left;
    logic [7:0]  b;

    in_bus.valid <= 1'b0;
    in_bus.ch    <= '0;
    rst_n        <= 1'b0;
    op_set = "+-*/&|!<>()[];,";

    // Byte extremes, both keywords, a plain word, a number run into a word,
    // an identifier cut by a stray byte (three tokens), an empty string,
    // equals followed by a letter, and a comment
    source_text.push_back(8'h00);
    source_text.push_back(8'hFF);
    directed = "if(while{ab 12x$a.\"\"=a#\n";
    for (int i = 0; i < directed.len(); i++) source_text.push_back(directed[i]);

    // Random token stream: mostly well-formed tokens, some noise and run-ons
    while (source_text.size() < SOURCE_BYTES) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          directed = ($urandom_range(0, 1) == 0) ? "if" : "while";
          for (int i = 0; i < directed.len(); i++) source_text.push_back(directed[i]);
        end
        2, 3: begin
          n = $urandom_range(1, 6);
          repeat (n) source_text.push_back(8'("a" + $urandom_range(0, 25)));
        end
        4, 5: begin
          source_text.push_back(($urandom_range(0, 1) == 0) ? slt_pkg::CH_DOLLAR :
                                                              slt_pkg::CH_QUEST);
          n = $urandom_range(0, 5);
          repeat (n) begin
            case ($urandom_range(0, 3))
              0:       b = 8'("a" + $urandom_range(0, 25));
              1:       b = 8'("A" + $urandom_range(0, 25));
              2:       b = 8'("0" + $urandom_range(0, 9));
              default: b = slt_pkg::CH_UNDER;
            endcase
            source_text.push_back(b);
          end
        end
        6, 7: begin
          n = $urandom_range(1, 5);
          repeat (n) source_text.push_back(8'("0" + $urandom_range(0, 9)));
        end
        8, 9: begin
          source_text.push_back(slt_pkg::CH_QUOTE);
          n = $urandom_range(0, 6);
          repeat (n) begin
            do b = 8'($urandom_range(0, 255)); while (b == slt_pkg::CH_QUOTE);
            source_text.push_back(b);
          end
          source_text.push_back(slt_pkg::CH_QUOTE);
        end
        10, 11: source_text.push_back(op_set[$urandom_range(0, 14)]);
        12: begin
          source_text.push_back(slt_pkg::CH_EQ);
          case ($urandom_range(0, 4))
            0: source_text.push_back(slt_pkg::CH_EQ);
            1: source_text.push_back(slt_pkg::CH_BANG);
            2: source_text.push_back(slt_pkg::CH_LT);
            3: source_text.push_back(slt_pkg::CH_GT);
            default: ;
          endcase
        end
        13: source_text.push_back(($urandom_range(0, 1) == 0) ? slt_pkg::CH_LBRACE :
                                                                slt_pkg::CH_RBRACE);
        14: begin
          source_text.push_back(slt_pkg::CH_HASH);
          n = $urandom_range(0, 5);
          repeat (n) begin
            do b = 8'($urandom_range(0, 255)); while (b == slt_pkg::CH_NL);
            source_text.push_back(b);
          end
          source_text.push_back(slt_pkg::CH_NL);
        end
        default: source_text.push_back(8'($urandom_range(0, 255)));
      endcase
      // Separator: usually whitespace or an operator, sometimes none at all
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: source_text.push_back(slt_pkg::CH_SP);
        5:             source_text.push_back(slt_pkg::CH_TAB);
        6:             source_text.push_back(slt_pkg::CH_NL);
        7:             source_text.push_back(op_set[$urandom_range(0, 14)]);
        default: ;
      endcase
    end

    source_text.push_back(";");
    source_text.push_back(slt_pkg::CH_NL);
    // A word left open at the end must never come out
    source_text.push_back(slt_pkg::CH_W);
    source_text.push_back(slt_pkg::CH_H);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Stream bytes in bursts of random length with random gaps between them
    burst_left = 0;
    foreach (source_text[i]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 64);
        n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (n != 0) begin
          in_bus.valid <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      burst_left--;
      in_bus.valid <= 1'b1;
      in_bus.ch    <= source_text[i];
      @(posedge clk);
      while (!in_bus.ready) @(posedge clk);
    end
    in_bus.valid <= 1'b0;

    // Drain every predicted token, then watch for strays
    do @(posedge clk); while (tokens_outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("** script_lexer_tokenizer_unit: PASSED **");
    else
      $display("** script_lexer_tokenizer_unit: FAILED **");
    $finish;
  end

endmodule
